/* rtl/core/tfd_pkg.sv */
package tfd_pkg;

  localparam int unsigned COUNT_BYTES   = 4;
  localparam int unsigned LEB_MAX_BYTES = 5;
  localparam int unsigned QUEUE_DEPTH   = 4;

  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 80;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_COUNT,
    PH_LEN,
    PH_DATA,
    PH_DONE,
    PH_ERROR
  } phase_t;

  typedef enum logic [1:0] {
    KIND_HEADER,
    KIND_DATA,
    KIND_DONE,
    KIND_ERROR
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data_byte;
    logic [31:0] field_index;
    logic [31:0] field_length;
    logic        field_end;
    logic        last_in_step;
  } res_t;

  // Up to two results leave the parser for one input item.
  typedef struct packed {
    logic va;
    logic vb;
    res_t a;
    res_t b;
  } push_t;

endpackage

/* rtl/core/tfd_front.sv */
module tfd_front
  import tfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  byte_value,
  input  logic        first_byte,
  input  logic [31:0] record_length,
  output push_t       push
);

  phase_t      phase_r, phase_nxt;
  logic [31:0] bytes_left_r, bytes_left_nxt;
  logic [1:0]  cbn_r, cbn_nxt;
  logic [31:0] fields_left_r, fields_left_nxt;
  logic [31:0] cur_field_r, cur_field_nxt;
  logic [31:0] accum_r, accum_nxt;
  logic [2:0]  lbn_r, lbn_nxt;
  logic [31:0] data_left_r, data_left_nxt;

  phase_t      ph;
  logic [31:0] bl, fl, cur, acc, dl;
  logic [1:0]  cbn;
  logic [2:0]  lbn;
  logic [31:0] fl_or, acc_or;
  logic        accept;
  logic        ra_v, rb_v;
  res_t        ra, rb;

  function automatic res_t mk_res(kind_t k, logic [7:0] d, logic [31:0] idx,
                                  logic [31:0] len, logic fe);
    res_t r;
    r.kind         = k;
    r.data_byte    = d;
    r.field_index  = idx;
    r.field_length = len;
    r.field_end    = fe;
    r.last_in_step = 1'b0;
    return r;
  endfunction

  function automatic logic [4:0] leb_shift(logic [2:0] n);
    logic [4:0] s;
    case (n)
      3'd0:    s = 5'd0;
      3'd1:    s = 5'd7;
      3'd2:    s = 5'd14;
      3'd3:    s = 5'd21;
      3'd4:    s = 5'd28;
      default: s = 5'd0;
    endcase
    return s;
  endfunction

  assign accept = in_valid & in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_IDLE;
      bytes_left_r  <= '0;
      cbn_r         <= '0;
      fields_left_r <= '0;
      cur_field_r   <= '0;
      accum_r       <= '0;
      lbn_r         <= '0;
      data_left_r   <= '0;
    end else if (accept) begin
      phase_r       <= phase_nxt;
      bytes_left_r  <= bytes_left_nxt;
      cbn_r         <= cbn_nxt;
      fields_left_r <= fields_left_nxt;
      cur_field_r   <= cur_field_nxt;
      accum_r       <= accum_nxt;
      lbn_r         <= lbn_nxt;
      data_left_r   <= data_left_nxt;
    end
  end

  always_comb begin
    // A first byte restarts the parser from a clean state.
    ph  = first_byte ? PH_COUNT : phase_r;
    bl  = first_byte ? record_length : bytes_left_r;
    cbn = first_byte ? 2'd0 : cbn_r;
    fl  = first_byte ? 32'd0 : fields_left_r;
    cur = first_byte ? 32'd0 : cur_field_r;
    acc = first_byte ? 32'd0 : accum_r;
    lbn = first_byte ? 3'd0 : lbn_r;
    dl  = first_byte ? 32'd0 : data_left_r;

    fl_or  = fl | ({24'd0, byte_value} << {cbn, 3'b000});
    acc_or = acc | ({25'd0, byte_value[6:0]} << leb_shift(lbn));

    phase_nxt       = ph;
    bytes_left_nxt  = bl;
    cbn_nxt         = cbn;
    fields_left_nxt = fl;
    cur_field_nxt   = cur;
    accum_nxt       = acc;
    lbn_nxt         = lbn;
    data_left_nxt   = dl;

    ra_v = 1'b0;
    rb_v = 1'b0;
    ra   = '0;
    rb   = '0;

    if (ph == PH_COUNT || ph == PH_LEN || ph == PH_DATA) begin
      if (bl == 32'd0) begin
        ra_v      = 1'b1;
        ra        = mk_res(KIND_ERROR, 8'd0, cur, 32'd0, 1'b0);
        phase_nxt = PH_ERROR;
      end else begin
        bytes_left_nxt = bl - 32'd1;
        case (ph)
          PH_COUNT: begin
            fields_left_nxt = fl_or;
            if (cbn == 2'(COUNT_BYTES - 1)) begin
              if (fl_or == 32'd0) begin
                ra_v      = 1'b1;
                ra        = mk_res(KIND_DONE, 8'd0, cur, 32'd0, 1'b0);
                phase_nxt = PH_DONE;
              end else begin
                phase_nxt = PH_LEN;
                accum_nxt = '0;
                lbn_nxt   = '0;
              end
            end else begin
              cbn_nxt = cbn + 2'd1;
            end
          end
          PH_LEN: begin
            accum_nxt = acc_or;
            if (byte_value[7]) begin
              if (lbn >= 3'(LEB_MAX_BYTES - 1)) begin
                ra_v      = 1'b1;
                ra        = mk_res(KIND_ERROR, 8'd0, cur, 32'd0, 1'b0);
                phase_nxt = PH_ERROR;
              end else begin
                lbn_nxt = lbn + 3'd1;
              end
            end else if (acc_or >= bl) begin
              // The field would run past the bytes left after this one.
              ra_v      = 1'b1;
              ra        = mk_res(KIND_ERROR, 8'd0, cur, 32'd0, 1'b0);
              phase_nxt = PH_ERROR;
            end else begin
              ra_v          = 1'b1;
              ra            = mk_res(KIND_HEADER, 8'd0, cur, acc_or, 1'b0);
              data_left_nxt = acc_or;
              if (acc_or == 32'd0) begin
                cur_field_nxt   = cur + 32'd1;
                fields_left_nxt = fl - 32'd1;
                if (fl == 32'd1) begin
                  rb_v      = 1'b1;
                  rb        = mk_res(KIND_DONE, 8'd0, cur + 32'd1, 32'd0, 1'b0);
                  phase_nxt = PH_DONE;
                end else begin
                  phase_nxt = PH_LEN;
                  accum_nxt = '0;
                  lbn_nxt   = '0;
                end
              end else begin
                phase_nxt = PH_DATA;
              end
            end
          end
          PH_DATA: begin
            data_left_nxt = dl - 32'd1;
            ra_v          = 1'b1;
            ra            = mk_res(KIND_DATA, byte_value, cur, acc, dl == 32'd1);
            if (dl == 32'd1) begin
              cur_field_nxt   = cur + 32'd1;
              fields_left_nxt = fl - 32'd1;
              if (fl == 32'd1) begin
                rb_v      = 1'b1;
                rb        = mk_res(KIND_DONE, 8'd0, cur + 32'd1, 32'd0, 1'b0);
                phase_nxt = PH_DONE;
              end else begin
                phase_nxt = PH_LEN;
                accum_nxt = '0;
                lbn_nxt   = '0;
              end
            end
          end
          default: ;
        endcase

        // The record ran out while fields are still open.
        if ((phase_nxt == PH_COUNT || phase_nxt == PH_LEN || phase_nxt == PH_DATA) &&
            bl == 32'd1) begin
          phase_nxt = PH_ERROR;
          if (ra_v) begin
            rb_v = 1'b1;
            rb   = mk_res(KIND_ERROR, 8'd0, cur_field_nxt, 32'd0, 1'b0);
          end else begin
            ra_v = 1'b1;
            ra   = mk_res(KIND_ERROR, 8'd0, cur_field_nxt, 32'd0, 1'b0);
          end
        end
      end
    end

    ra.last_in_step = ~rb_v;
    rb.last_in_step = 1'b1;

    push.va = accept & ra_v;
    push.vb = accept & rb_v;
    push.a  = ra;
    push.b  = rb;
  end

endmodule

/* rtl/core/tfd_queue.sv */
module tfd_queue
  import tfd_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic  clk,
  input  logic  rst_n,
  input  push_t push,
  output logic  room,
  output logic  head_valid,
  output res_t  head,
  input  logic  pop
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  res_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [PTR_W-1:0] wr_ptr_p1;

  function automatic logic [PTR_W-1:0] inc_ptr(logic [PTR_W-1:0] p);
    return (p == LAST_PTR) ? '0 : p + PTR_W'(1);
  endfunction

  assign wr_ptr_p1  = inc_ptr(wr_ptr_r);
  assign room       = cnt_r <= CNT_W'(DEPTH - 2);
  assign head_valid = cnt_r != '0;
  assign head       = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    if (push.va && push.vb) begin
      wr_ptr_nxt = inc_ptr(wr_ptr_p1);
    end else if (push.va) begin
      wr_ptr_nxt = wr_ptr_p1;
    end
    rd_ptr_nxt = pop ? inc_ptr(rd_ptr_r) : rd_ptr_r;
    cnt_nxt    = cnt_r + CNT_W'(push.va) + CNT_W'(push.vb) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.va) begin
      mem[wr_ptr_r] <= push.a;
    end
    if (push.vb) begin
      mem[wr_ptr_p1] <= push.b;
    end
  end

endmodule

/* rtl/core/tfd_back.sv */
module tfd_back
  import tfd_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic head_valid,
  input  res_t head,
  output logic pop,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_res
);

  logic out_valid_r, out_valid_nxt;
  res_t out_res_r;

  assign pop           = head_valid & (~out_valid_r | out_ready);
  assign out_valid_nxt = pop | (out_valid_r & ~out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_res_r <= head;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

/* rtl/core/tuple_record_field_deframer_top.sv */
// Record field deframer.
// The in_ channel takes one record byte per item; in_tuser marks the first
// byte of a record, which restarts parsing and carries the total record length.
// The out_ channel gives one result per item: a field header, a data byte,
// a record-done marker or a format error (kind in out_tuser). out_tlast marks
// the last result caused by one input byte.
// A result passes through the result queue and the output register once its
// byte is accepted. Throughput: one byte per cycle while each byte gives at
// most one result and out_tready stays high; a byte that gives two results
// (header or last data byte followed by done or error) writes both at once.
// The parser decodes each byte combinationally; a four-entry result queue
// and an output register sit behind it, so in_tready drops only when the
// queue cannot take two more results.
// Reset (rst_n low, synchronous) empties the queue, drops out_tvalid and
// returns the parser to idle, where bytes are dropped until a first byte.
// When the receiver stalls, the output holds and the queue fills; input
// stalls once it is nearly full.
module tuple_record_field_deframer_top
  import tfd_pkg::*;
#(
  parameter int unsigned QDEPTH = QUEUE_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [7:0] byte_value, [39:8] record_length
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // [0] first_byte
  input  logic                   in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [7:0] data_byte, [39:8] field_index, [71:40] field_length, [72] field_end,
  // [79:73] zero
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // [1:0] kind
  output logic [1:0]             out_tuser,
  output logic                   out_tlast
);

  push_t push;
  logic  room;
  logic  head_valid;
  res_t  head;
  logic  pop;
  res_t  out_res;

  assign in_tready = room;

  tfd_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_tvalid),
    .in_ready     (room),
    .byte_value   (in_tdata[7:0]),
    .first_byte   (in_tuser),
    .record_length(in_tdata[39:8]),
    .push         (push)
  );

  tfd_queue #(
    .DEPTH(QDEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .head_valid(head_valid),
    .head      (head),
    .pop       (pop)
  );

  tfd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_valid(head_valid),
    .head      (head),
    .pop       (pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  assign out_tdata = {7'd0, out_res.field_end, out_res.field_length,
                      out_res.field_index, out_res.data_byte};
  assign out_tuser = out_res.kind;
  assign out_tlast = out_res.last_in_step;

endmodule

/* rtl/core/tfd_checker.sv */
module tfd_checker
  import tfd_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic [1:0]             out_tuser,
  input logic                   out_tlast
);

  // A stalled result keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
    $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled result changed");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // Nothing follows an error or a done result within one byte.
  a_error_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == KIND_ERROR || out_tuser == KIND_DONE) |-> out_tlast)
    else $error("done or error not last of its byte");

  a_header_no_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_HEADER |-> !out_tdata[72])
    else $error("header carries field end");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[79:73] == 7'd0)
    else $error("padding bits set");

endmodule

bind tuple_record_field_deframer_top tfd_checker u_tfd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tuser (out_tuser),
  .out_tlast (out_tlast)
);
